// ----- rtl/fpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types, register indexes and tables of the fisheye coordinate
// generator.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int CORD_W       = 24;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 36;
    localparam int ANGLE_W      = 33;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_K1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_K2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_K3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_K4 = 3'd7;

    localparam logic [63:0] SAT_MAG = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE_Q28 = 64'h0000_0000_1000_0000;

    localparam logic signed [63:0] CORD_MAX = 64'sd8388607;
    localparam logic signed [63:0] CORD_MIN = -64'sd8388608;

    typedef struct packed {
        logic zero;
        logic sx;
    } divx_side_t;

    typedef struct packed {
        logic        zero;
        logic        sx;
        logic        sy;
        logic [4:0]  s;
        logic [30:0] a;
        logic [30:0] b;
    } root_side_t;

    typedef struct packed {
        logic        zero;
        logic        sx;
        logic [4:0]  s;
        logic [31:0] rr;
    } dir_side_t;

    typedef struct packed {
        logic        zero;
        logic        sx;
        logic        sy;
        logic [30:0] dir_x;
        logic [30:0] dir_y;
    } ang_side_t;

    typedef struct packed {
        logic        zero;
        logic        sx;
        logic        sy;
        logic [30:0] dir_x;
        logic [30:0] dir_y;
        logic [30:0] theta;
        logic [31:0] t;
    } poly_side_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314856;
            1:       v = 32'd497837829;
            2:       v = 32'd263043836;
            3:       v = 32'd133525158;
            4:       v = 32'd67021686;
            5:       v = 32'd33543515;
            6:       v = 32'd16775850;
            7:       v = 32'd8388437;
            8:       v = 32'd4194282;
            9:       v = 32'd2097149;
            10:      v = 32'd1048575;
            11:      v = 32'd524287;
            12:      v = 32'd262143;
            13:      v = 32'd131071;
            14:      v = 32'd65535;
            15:      v = 32'd32767;
            16:      v = 32'd16383;
            17:      v = 32'd8191;
            18:      v = 32'd4095;
            19:      v = 32'd2047;
            20:      v = 32'd1023;
            21:      v = 32'd511;
            22:      v = 32'd255;
            23:      v = 32'd127;
            24:      v = 32'd63;
            25:      v = 32'd31;
            26:      v = 32'd15;
            27:      v = 32'd7;
            28:      v = 32'd3;
            29:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // shift right, rounding toward zero
    function automatic logic [CORDIC_W-1:0] asr_tz(input logic [CORDIC_W-1:0] v,
                                                   input int i);
        logic [CORDIC_W-1:0] m;
        logic [CORDIC_W-1:0] s;
        m = v[CORDIC_W-1] ? (~v + 1'b1) : v;
        s = m >> i;
        return v[CORDIC_W-1] ? (~s + 1'b1) : s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/fisheye_pixel_distortion.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fisheye_pixel_distortion
// Fisheye lens distortion coordinate generator for a dewarp engine.
// Throughput: one word per cycle; busy stays low, every stage is pipelined
// (input dividers 57 stages, root 32, direction dividers 31, CORDIC 30).
// The receiver cannot stall: each result shows for one cycle with done.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module fisheye_pixel_distortion
    import fpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [23:0]   in_x,
    input  wire logic signed [23:0]   in_y,
    output logic                      done,
    output logic signed [23:0]        out_x,
    output logic signed [23:0]        out_y,
    output logic                      saturated,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);

    localparam int LAT = 1 + 57 + 3 + 32 + 31 + CORDIC_STEPS + 1 + 10 + 4;

    logic [23:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [31:0] coeff_k1_reg, coeff_k2_reg, coeff_k3_reg, coeff_k4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 24'd256;
            focal_y_reg  <= 24'd256;
            center_x_reg <= '0;
            center_y_reg <= '0;
            coeff_k1_reg <= '0;
            coeff_k2_reg <= '0;
            coeff_k3_reg <= '0;
            coeff_k4_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FOCAL_X:  focal_x_reg  <= wr_data[23:0];
                REG_FOCAL_Y:  focal_y_reg  <= wr_data[23:0];
                REG_CENTER_X: center_x_reg <= wr_data[23:0];
                REG_CENTER_Y: center_y_reg <= wr_data[23:0];
                REG_COEFF_K1: coeff_k1_reg <= wr_data;
                REG_COEFF_K2: coeff_k2_reg <= wr_data;
                REG_COEFF_K3: coeff_k3_reg <= wr_data;
                REG_COEFF_K4: coeff_k4_reg <= wr_data;
                default: ;
            endcase
        end
    end

    logic [23:0] fx_eff, fy_eff;
    assign fx_eff = (focal_x_reg == '0) ? 24'd1 : focal_x_reg;
    assign fy_eff = (focal_y_reg == '0) ? 24'd1 : focal_y_reg;

    assign busy = 1'b0;

    // offset from the principal point
    logic [24:0] dx, dy, mx_next, my_next;
    logic        s0_valid_reg, zero0_reg, sx0_reg, sy0_reg;
    logic [24:0] mx0_reg, my0_reg;

    assign dx      = {in_x[23], in_x} - {center_x_reg[23], center_x_reg};
    assign dy      = {in_y[23], in_y} - {center_y_reg[23], center_y_reg};
    assign mx_next = dx[24] ? (~dx + 1'b1) : dx;
    assign my_next = dy[24] ? (~dy + 1'b1) : dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        zero0_reg <= (dx == '0) && (dy == '0);
        sx0_reg   <= dx[24];
        sy0_reg   <= dy[24];
        mx0_reg   <= mx_next;
        my0_reg   <= my_next;
    end

    // normalize by focal length
    divx_side_t divx_in, divx_out;
    logic       divx_valid, divy_valid, divy_side;
    logic [56:0] ux, uy;

    assign divx_in = '{zero: zero0_reg, sx: sx0_reg};

    fpd_udiv #(.DW(57), .VW(24), .QW(57), .SW($bits(divx_side_t))) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .num       ({mx0_reg, 32'd0}),
        .den       (fx_eff),
        .in_side   (divx_in),
        .out_valid (divx_valid),
        .quo       (ux),
        .out_side  (divx_out)
    );

    fpd_udiv #(.DW(57), .VW(24), .QW(57), .SW(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .num       ({my0_reg, 32'd0}),
        .den       (fy_eff),
        .in_side   (sy0_reg),
        .out_valid (divy_valid),
        .quo       (uy),
        .out_side  (divy_side)
    );

    // common shift so both magnitudes fit 31 bits
    logic [56:0] amax;
    logic [4:0]  sh_next;
    logic [56:0] ua_sh, ub_sh;

    assign amax = (ux > uy) ? ux : uy;

    always_comb
    begin
        sh_next = '0;
        for (int i = 31; i < 57; i++)
        begin
            if (amax[i])
            begin
                sh_next = 5'(i - 30);
            end
        end
    end

    assign ua_sh = ux >> sh_next;
    assign ub_sh = uy >> sh_next;

    root_side_t  n1_reg, n2_reg, n3_reg;
    logic        n1_valid_reg, n2_valid_reg, n3_valid_reg;
    logic [61:0] sqa_reg, sqb_reg;
    logic [62:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            n3_valid_reg <= 1'b0;
        end
        else
        begin
            n1_valid_reg <= divx_valid && divy_valid;
            n2_valid_reg <= n1_valid_reg;
            n3_valid_reg <= n2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg  <= '{zero: divx_out.zero, sx: divx_out.sx, sy: divy_side,
                     s: sh_next, a: ua_sh[30:0], b: ub_sh[30:0]};
        n2_reg  <= n1_reg;
        sqa_reg <= {31'd0, n1_reg.a} * {31'd0, n1_reg.a};
        sqb_reg <= {31'd0, n1_reg.b} * {31'd0, n1_reg.b};
        n3_reg  <= n2_reg;
        sum_reg <= {1'b0, sqa_reg} + {1'b0, sqb_reg};
    end

    // radius
    root_side_t  rt_out;
    logic        rt_valid;
    logic [31:0] root, rr;

    fpd_isqrt #(.SW($bits(root_side_t))) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n3_valid_reg),
        .n         (sum_reg),
        .in_side   (n3_reg),
        .out_valid (rt_valid),
        .root      (root),
        .out_side  (rt_out)
    );

    assign rr = (root == '0) ? 32'd1 : root;

    // direction cosines
    dir_side_t   dir_in, dir_out;
    logic        dirx_valid, diry_valid, diry_side;
    logic [30:0] dir_x, dir_y;

    assign dir_in = '{zero: rt_out.zero, sx: rt_out.sx, s: rt_out.s, rr: rr};

    fpd_udiv #(.DW(61), .VW(32), .QW(31), .SW($bits(dir_side_t))) u_dir_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .num       ({rt_out.a, 30'd0}),
        .den       (rr),
        .in_side   (dir_in),
        .out_valid (dirx_valid),
        .quo       (dir_x),
        .out_side  (dir_out)
    );

    fpd_udiv #(.DW(61), .VW(32), .QW(31), .SW(1)) u_dir_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .num       ({rt_out.b, 30'd0}),
        .den       (rr),
        .in_side   (rt_out.sy),
        .out_valid (diry_valid),
        .quo       (dir_y),
        .out_side  (diry_side)
    );

    // theta = atan(r)
    ang_side_t           ang_in, ang_out;
    logic                ang_valid;
    logic [30:0]         theta;
    logic [CORDIC_W-1:0] cx0;

    assign ang_in = '{zero: dir_out.zero, sx: dir_out.sx, sy: diry_side,
                      dir_x: dir_x, dir_y: dir_y};
    assign cx0    = CORDIC_W'(1) << (6'd32 - {1'b0, dir_out.s});

    fpd_cordic #(.SW($bits(ang_side_t))) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dirx_valid && diry_valid),
        .x0        (cx0),
        .y0        (CORDIC_W'(dir_out.rr)),
        .in_side   (ang_in),
        .out_valid (ang_valid),
        .theta     (theta),
        .out_side  (ang_out)
    );

    // theta squared
    logic        t_valid_reg;
    ang_side_t   t_side_reg;
    logic [30:0] t_theta_reg;
    logic [61:0] tsq_reg;
    poly_side_t  ps0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= ang_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t_side_reg  <= ang_out;
        t_theta_reg <= theta;
        tsq_reg     <= {31'd0, theta} * {31'd0, theta};
    end

    assign ps0 = '{zero: t_side_reg.zero, sx: t_side_reg.sx, sy: t_side_reg.sy,
                   dir_x: t_side_reg.dir_x, dir_y: t_side_reg.dir_y,
                   theta: t_theta_reg, t: tsq_reg[61:30]};

    // Horner evaluation of theta_d
    logic [63:0] k1s, k2s, k3s, k4s;
    assign k1s = {{32{coeff_k1_reg[31]}}, coeff_k1_reg};
    assign k2s = {{32{coeff_k2_reg[31]}}, coeff_k2_reg};
    assign k3s = {{32{coeff_k3_reg[31]}}, coeff_k3_reg};
    assign k4s = {{32{coeff_k4_reg[31]}}, coeff_k4_reg};

    logic        hv1, hv2, hv3, hv4, hv5;
    logic [63:0] hp1, hp2, hp3, hp4, td;
    poly_side_t  hs1, hs2, hs3, hs4, hs5;

    fpd_qmul #(.SW($bits(poly_side_t))) u_h1 (
        .clk(clk), .rst_n(rst_n), .in_valid(t_valid_reg), .p(k4s), .b(ps0.t),
        .addend(k3s), .in_side(ps0), .out_valid(hv1), .p_out(hp1), .out_side(hs1)
    );

    fpd_qmul #(.SW($bits(poly_side_t))) u_h2 (
        .clk(clk), .rst_n(rst_n), .in_valid(hv1), .p(hp1), .b(hs1.t),
        .addend(k2s), .in_side(hs1), .out_valid(hv2), .p_out(hp2), .out_side(hs2)
    );

    fpd_qmul #(.SW($bits(poly_side_t))) u_h3 (
        .clk(clk), .rst_n(rst_n), .in_valid(hv2), .p(hp2), .b(hs2.t),
        .addend(k1s), .in_side(hs2), .out_valid(hv3), .p_out(hp3), .out_side(hs3)
    );

    fpd_qmul #(.SW($bits(poly_side_t))) u_h4 (
        .clk(clk), .rst_n(rst_n), .in_valid(hv3), .p(hp3), .b(hs3.t),
        .addend(ONE_Q28), .in_side(hs3), .out_valid(hv4), .p_out(hp4), .out_side(hs4)
    );

    fpd_qmul #(.SW($bits(poly_side_t))) u_h5 (
        .clk(clk), .rst_n(rst_n), .in_valid(hv4), .p(hp4), .b({1'b0, hs4.theta}),
        .addend(64'd0), .in_side(hs4), .out_valid(hv5), .p_out(td), .out_side(hs5)
    );

    // back to pixels
    logic        px_valid, py_valid, sat_x, sat_y;
    logic [23:0] coord_x, coord_y;

    fpd_place u_place_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hv5),
        .zero      (hs5.zero),
        .dneg      (hs5.sx),
        .dir       (hs5.dir_x),
        .td        (td),
        .focal     (fx_eff),
        .center    (center_x_reg),
        .out_valid (px_valid),
        .coord     (coord_x),
        .sat       (sat_x)
    );

    fpd_place u_place_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hv5),
        .zero      (hs5.zero),
        .dneg      (hs5.sy),
        .dir       (hs5.dir_y),
        .td        (td),
        .focal     (fy_eff),
        .center    (center_y_reg),
        .out_valid (py_valid),
        .coord     (coord_y),
        .sat       (sat_y)
    );

    assign done      = px_valid && py_valid;
    assign out_x     = signed'(coord_x);
    assign out_y     = signed'(coord_y);
    assign saturated = sat_x || sat_y;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result missing after pipeline latency");

    a_sat_done: assert property (@(posedge clk) disable iff (!rst_n)
        saturated |-> done)
        else $error("saturation flag outside a result");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        saturated |-> (out_x == 24'sh7FFFFF || out_x == -24'sh800000 ||
                       out_y == 24'sh7FFFFF || out_y == -24'sh800000))
        else $error("saturation flag without a clamped coordinate");

endmodule
`default_nettype wire

// ----- rtl/fpd_udiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_udiv
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpd_udiv #(
    parameter int DW = 57,
    parameter int VW = 24,
    parameter int QW = 57,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] num,
    input  wire logic [VW-1:0] den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      out_side
);

    localparam int CW = (DW > VW + QW) ? DW : VW + QW;

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [VW-1:0] d_reg   [QW];
    logic [SW-1:0] s_reg   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [VW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [CW-1:0] shd;
        logic          take;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = num;
            assign q_in   = '0;
            assign d_in   = den;
            assign s_in   = in_side;
        end else begin : g_next
            assign v_in   = v_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign s_in   = s_reg[j-1];
        end

        assign shd  = CW'(d_in) << K;
        assign take = CW'(rem_in) >= shd;

        always_comb
        begin
            rem_next = take ? DW'(CW'(rem_in) - shd) : rem_in;
            q_next   = q_in;
            q_next[K] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            q_reg[j]   <= q_next;
            d_reg[j]   <= d_in;
            s_reg[j]   <= s_in;
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign out_side  = s_reg[QW-1];

endmodule
`default_nettype wire

// ----- rtl/fpd_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_isqrt
// Pipelined integer square root of a 63-bit word, one root bit per stage.
// ----------------------------------------------------------------------------
module fpd_isqrt #(
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [62:0]   n,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [31:0]        root,
    output logic [SW-1:0]      out_side
);

    localparam int STEPS = 32;

    logic          v_reg   [STEPS];
    logic [62:0]   n_reg   [STEPS];
    logic [63:0]   res_reg [STEPS];
    logic [SW-1:0] s_reg   [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_stage
        localparam int B = 62 - 2 * j;
        logic          v_in;
        logic [62:0]   n_in;
        logic [63:0]   res_in;
        logic [SW-1:0] s_in;
        logic [63:0]   sum;
        logic          take;
        logic [62:0]   n_next;
        logic [63:0]   res_next;

        if (j == 0) begin : g_first
            assign v_in   = in_valid;
            assign n_in   = n;
            assign res_in = '0;
            assign s_in   = in_side;
        end else begin : g_next
            assign v_in   = v_reg[j-1];
            assign n_in   = n_reg[j-1];
            assign res_in = res_reg[j-1];
            assign s_in   = s_reg[j-1];
        end

        assign sum      = res_in + (64'd1 << B);
        assign take     = {1'b0, n_in} >= sum;
        assign n_next   = take ? 63'({1'b0, n_in} - sum) : n_in;
        assign res_next = take ? ((res_in >> 1) + (64'd1 << B)) : (res_in >> 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[j]   <= n_next;
            res_reg[j] <= res_next;
            s_reg[j]   <= s_in;
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][31:0];
    assign out_side  = s_reg[STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/fpd_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_cordic
// Pipelined CORDIC in vectoring mode, returns atan(y/x) in Q30.
// ----------------------------------------------------------------------------
module fpd_cordic
    import fpd_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [CORDIC_W-1:0] x0,
    input  wire logic [CORDIC_W-1:0] y0,
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_valid,
    output logic [30:0]              theta,
    output logic [SW-1:0]            out_side
);

    logic                v_reg [CORDIC_STEPS];
    logic [CORDIC_W-1:0] x_reg [CORDIC_STEPS];
    logic [CORDIC_W-1:0] y_reg [CORDIC_STEPS];
    logic [ANGLE_W-1:0]  z_reg [CORDIC_STEPS];
    logic [SW-1:0]       s_reg [CORDIC_STEPS];

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_stage
        localparam logic [ANGLE_W-1:0] ANG = ANGLE_W'(atan_q30(j));
        logic                v_in;
        logic [CORDIC_W-1:0] x_in;
        logic [CORDIC_W-1:0] y_in;
        logic [ANGLE_W-1:0]  z_in;
        logic [SW-1:0]       s_in;
        logic [CORDIC_W-1:0] xs;
        logic [CORDIC_W-1:0] ys;
        logic                up;
        logic [CORDIC_W-1:0] x_next;
        logic [CORDIC_W-1:0] y_next;
        logic [ANGLE_W-1:0]  z_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign x_in = x0;
            assign y_in = y0;
            assign z_in = '0;
            assign s_in = in_side;
        end else begin : g_next
            assign v_in = v_reg[j-1];
            assign x_in = x_reg[j-1];
            assign y_in = y_reg[j-1];
            assign z_in = z_reg[j-1];
            assign s_in = s_reg[j-1];
        end

        assign xs = asr_tz(x_in, j);
        assign ys = asr_tz(y_in, j);
        assign up = !y_in[CORDIC_W-1] && (y_in != '0);

        assign x_next = up ? (x_in + ys) : (x_in - ys);
        assign y_next = up ? (y_in - xs) : (y_in + xs);
        assign z_next = up ? (z_in + ANG) : (z_in - ANG);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[j] <= x_next;
            y_reg[j] <= y_next;
            z_reg[j] <= z_next;
            s_reg[j] <= s_in;
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign theta     = z_reg[CORDIC_STEPS-1][ANGLE_W-1] ? '0
                                                        : z_reg[CORDIC_STEPS-1][30:0];
    assign out_side  = s_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/fpd_qmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_qmul
// Two-stage signed by unsigned Q30 multiply with magnitude saturation,
// followed by an add; one Horner step.
// ----------------------------------------------------------------------------
module fpd_qmul
    import fpd_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [63:0]   p,
    input  wire logic [31:0]   b,
    input  wire logic [63:0]   addend,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [63:0]        p_out,
    output logic [SW-1:0]      out_side
);

    logic [63:0]   pm;
    logic [63:0]   pl_next;
    logic [62:0]   ph_next;

    logic          va_reg;
    logic [63:0]   pl_reg;
    logic [62:0]   ph_reg;
    logic          neg_reg;
    logic [63:0]   add_reg;
    logic [SW-1:0] sa_reg;

    logic [94:0]   full;
    logic [64:0]   sh;
    logic [63:0]   mg;
    logic [63:0]   p_next;

    logic          vb_reg;
    logic [63:0]   p_reg;
    logic [SW-1:0] sb_reg;

    assign pm      = p[63] ? (~p + 1'b1) : p;
    assign pl_next = {32'd0, pm[31:0]} * {32'd0, b};
    assign ph_next = {32'd0, pm[62:32]} * {31'd0, b};

    assign full   = {ph_reg, 32'd0} + {31'd0, pl_reg};
    assign sh     = full[94:30];
    assign mg     = (sh > {1'b0, SAT_MAG}) ? SAT_MAG : sh[63:0];
    assign p_next = add_reg + (neg_reg ? (~mg + 1'b1) : mg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg  <= pl_next;
        ph_reg  <= ph_next;
        neg_reg <= p[63];
        add_reg <= addend;
        sa_reg  <= in_side;
        p_reg   <= p_next;
        sb_reg  <= sa_reg;
    end

    assign out_valid = vb_reg;
    assign p_out     = p_reg;
    assign out_side  = sb_reg;

endmodule
`default_nettype wire

// ----- rtl/fpd_place.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_place
// Scale one axis by focal * direction * theta_d, round, add the principal
// point and clamp to the coordinate range.
// ----------------------------------------------------------------------------
module fpd_place
    import fpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              zero,
    input  wire logic              dneg,
    input  wire logic [30:0]       dir,
    input  wire logic [63:0]       td,
    input  wire logic [CORD_W-1:0] focal,
    input  wire logic [CORD_W-1:0] center,
    output logic                   out_valid,
    output logic [CORD_W-1:0]      coord,
    output logic                   sat
);

    logic [63:0]  tdm;
    logic [54:0]  fd_next;

    logic         v0_reg;
    logic         z0_reg;
    logic         n0_reg;
    logic [54:0]  fd_reg;
    logic [62:0]  tdm_reg;

    logic         v1_reg;
    logic         z1_reg;
    logic         n1_reg;
    logic [63:0]  pp0_reg;
    logic [62:0]  pp1_reg;
    logic [54:0]  pp2_reg;
    logic [53:0]  pp3_reg;

    logic [117:0] full;
    logic [60:0]  off_next;

    logic         v2_reg;
    logic         z2_reg;
    logic         n2_reg;
    logic [60:0]  off_reg;

    logic [63:0]  c64;
    logic [63:0]  off64;
    logic signed [63:0] o;
    logic [CORD_W-1:0]  coord_next;
    logic         sat_next;

    logic         v3_reg;
    logic [CORD_W-1:0] coord_reg;
    logic         sat_reg;

    assign tdm     = td[63] ? (~td + 1'b1) : td;
    assign fd_next = {31'd0, focal} * {24'd0, dir};

    assign full = {54'd0, pp0_reg}
                + {23'd0, pp1_reg, 32'd0}
                + {31'd0, pp2_reg, 32'd0}
                + {pp3_reg, 64'd0};
    assign off_next = 61'(({1'b0, full[117:57]} + 62'd1) >> 1);

    assign c64   = {{(64 - CORD_W){center[CORD_W-1]}}, center};
    assign off64 = {3'd0, off_reg};
    assign o     = signed'(c64 + (n2_reg ? (~off64 + 1'b1) : off64));

    always_comb
    begin
        sat_next   = 1'b0;
        coord_next = o[CORD_W-1:0];
        if (z2_reg)
        begin
            coord_next = center;
        end
        else if (o > CORD_MAX)
        begin
            coord_next = CORD_MAX[CORD_W-1:0];
            sat_next   = 1'b1;
        end
        else if (o < CORD_MIN)
        begin
            coord_next = CORD_MIN[CORD_W-1:0];
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            sat_reg <= 1'b0;
        end
        else
        begin
            v0_reg  <= in_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            sat_reg <= v2_reg && sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg    <= zero;
        n0_reg    <= dneg ^ td[63];
        fd_reg    <= fd_next;
        tdm_reg   <= tdm[62:0];
        z1_reg    <= z0_reg;
        n1_reg    <= n0_reg;
        pp0_reg   <= {32'd0, fd_reg[31:0]} * {32'd0, tdm_reg[31:0]};
        pp1_reg   <= 63'({32'd0, fd_reg[31:0]} * {33'd0, tdm_reg[62:32]});
        pp2_reg   <= 55'({9'd0, fd_reg[54:32]} * {32'd0, tdm_reg[31:0]});
        pp3_reg   <= 54'({8'd0, fd_reg[54:32]} * {23'd0, tdm_reg[62:32]});
        z2_reg    <= z1_reg;
        n2_reg    <= n1_reg;
        off_reg   <= off_next;
        coord_reg <= coord_next;
    end

    assign out_valid = v3_reg;
    assign coord     = coord_reg;
    assign sat       = sat_reg;

endmodule
`default_nettype wire
